// File: design/bfba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfba_pkg;

  // Fixed field widths
  localparam int SIZE_W     = 24;
  localparam int OUT_ADDR_W = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd1;

  // Reset values of the configuration registers
  localparam logic [CFG_DATA_W-1:0] HEAP_BASE_RST  = 32'h0000_0000;
  localparam logic [CFG_DATA_W-1:0] HEAP_LIMIT_RST = 32'hFFFF_FFFF;

  // Opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_ZERO = 3'd1,
    ST_OOM  = 3'd2,
    ST_FULL = 3'd3,
    ST_NULL = 3'd4
  } status_e;

endpackage

`default_nettype wire

// File: design/bfba_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module bfba_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic [AW-1:0]        raddr_i,
  output logic      [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/best_fit_block_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake                      Payload
// -------  -----------------------------  ---------------------------------------------
// in       in_valid_i / in_ready_o        opcode_i, request_size_i, payload_address_i
// out      out_valid_o / out_ready_i      status_o, granted_address_o, granted_size_o,
//                                         reused_o
// cfg      cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// One beat in, one beat out.
// Alloc scans the free table in RAM one entry per cycle and bumps the break
// pointer when no entry fits or the table is empty. On reuse the entries above
// the taken one are moved down one per cycle through the RAM.
// Reset empties the table and loads the break pointer with heap_base.
// A result waits in the output register while the next beat is accepted;
// the engine stalls only when a new result finds that register still full.
module best_fit_block_allocator_unit #(
  parameter int FREE_ENTRIES = 16,
  parameter int HEADER_BYTES = 16,
  parameter int ADDR_BITS    = 32
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // request channel
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic                                  opcode_i,
  input  wire logic [bfba_pkg::SIZE_W-1:0]           request_size_i,
  input  wire logic [bfba_pkg::OUT_ADDR_W-1:0]       payload_address_i,
  // result channel
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic      [2:0]                            status_o,
  output logic      [bfba_pkg::OUT_ADDR_W-1:0]       granted_address_o,
  output logic      [bfba_pkg::SIZE_W-1:0]           granted_size_o,
  output logic                                       reused_o,
  // configuration channel
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [bfba_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [bfba_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int SW    = bfba_pkg::SIZE_W;
  localparam int OW    = bfba_pkg::OUT_ADDR_W;
  localparam int IDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(FREE_ENTRIES + 1);
  localparam int ENT_W = ADDR_BITS + SW;
  // wide enough for any address plus carry and for the 32-bit registers
  localparam int CW    = (ADDR_BITS + 1 > OW + 1) ? ADDR_BITS + 1 : OW + 1;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_PICK     = 7'b0001000,
    S_SHIFT    = 7'b0010000,
    S_BUMP     = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // request
  logic                 op_q;
  logic [SW-1:0]        size_q;
  logic [OW-1:0]        paddr_q;

  // heap state
  logic [CNT_W-1:0]     count_q, count_d;
  logic [ADDR_BITS-1:0] bp_q;
  logic [OW-1:0]        limit_q;

  // scan and shift
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic [SW-1:0]        best_size_q, best_size_d;
  logic [ADDR_BITS-1:0] best_addr_q, best_addr_d;

  // result staging and output register
  bfba_pkg::status_e    res_status_q, res_status_d;
  logic [OW-1:0]        res_addr_q, res_addr_d;
  logic [SW-1:0]        res_size_q, res_size_d;
  logic                 res_reused_q, res_reused_d;
  logic                 bp_load;

  logic                 out_valid_q, out_valid_d;
  bfba_pkg::status_e    out_status_q;
  logic [OW-1:0]        out_addr_q;
  logic [SW-1:0]        out_size_q;
  logic                 out_reused_q;
  logic                 out_load;

  // RAM ports
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENT_W-1:0]     ram_rdata;

  bfba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (FREE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entry fields of the read beat
  logic [SW-1:0]        rd_size;
  logic [ADDR_BITS-1:0] rd_addr;
  logic                 rd_better;

  assign rd_size   = ram_rdata[SW-1:0];
  assign rd_addr   = ram_rdata[ENT_W-1:SW];
  // ties keep the first one seen, the scan runs newest to oldest
  assign rd_better = (rd_size >= size_q) && (!found_q || (rd_size < best_size_q));

  // Index arithmetic, one bit of headroom
  logic [CNT_W:0]       cnt_ext;
  logic [CNT_W:0]       cnt_m1;
  logic [CNT_W:0]       idx_ext;
  logic [CNT_W:0]       idx_p1;
  logic [CNT_W:0]       idx_p2;
  logic [CNT_W:0]       best_p1;

  assign cnt_ext = (CNT_W + 1)'(count_q);
  assign cnt_m1  = cnt_ext - (CNT_W + 1)'(1);
  assign idx_ext = (CNT_W + 1)'(idx_q);
  assign idx_p1  = idx_ext + (CNT_W + 1)'(1);
  assign idx_p2  = idx_ext + (CNT_W + 1)'(2);
  assign best_p1 = (CNT_W + 1)'(best_idx_q) + (CNT_W + 1)'(1);

  // Address width conversions
  logic [CW-1:0]        paddr_ext;
  logic [CW-1:0]        cfg_ext;
  logic [CW-1:0]        best_addr_ext;
  logic [CW-1:0]        bump_sum;
  logic [CW-1:0]        grant_full;
  logic [CW-1:0]        grant_trunc;
  logic                 bump_oom;

  assign paddr_ext     = CW'(paddr_q);
  assign cfg_ext       = CW'(cfg_data_i);
  assign best_addr_ext = CW'(best_addr_q);

  // Break pointer growth: header plus payload, checked for wrap and limit
  assign bump_sum    = CW'(bp_q) + CW'(HEADER_BYTES) + CW'(size_q);
  assign bump_oom    = (|bump_sum[CW-1:ADDR_BITS]) || (bump_sum > CW'(limit_q));
  assign grant_full  = CW'(bp_q) + CW'(HEADER_BYTES);
  assign grant_trunc = CW'(grant_full[ADDR_BITS-1:0]);

  // Control
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_size_d  = best_size_q;
    best_addr_d  = best_addr_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_size_d   = res_size_q;
    res_reused_d = res_reused_q;
    bp_load      = 1'b0;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = ram_rdata;
    ram_raddr    = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_status_d = bfba_pkg::ST_OK;
        res_addr_d   = '0;
        res_size_d   = '0;
        res_reused_d = 1'b0;
        found_d      = 1'b0;
        if (op_q == bfba_pkg::OP_FREE) begin
          state_d = S_DONE;
          if (paddr_q == '0) begin
            res_status_d = bfba_pkg::ST_NULL;
          end else if (cnt_ext >= (CNT_W + 1)'(FREE_ENTRIES)) begin
            res_status_d = bfba_pkg::ST_FULL;
          end else begin
            // push at the tail
            ram_we    = 1'b1;
            ram_waddr = count_q[IDX_W-1:0];
            ram_wdata = {paddr_ext[ADDR_BITS-1:0], size_q};
            count_d   = count_q + CNT_W'(1);
          end
        end else if (size_q == '0) begin
          res_status_d = bfba_pkg::ST_ZERO;
          state_d      = S_DONE;
        end else if (count_q == '0) begin
          state_d = S_BUMP;
        end else begin
          // start the scan at the newest entry
          ram_raddr = cnt_m1[IDX_W-1:0];
          idx_d     = cnt_m1[IDX_W-1:0];
          state_d   = S_SCAN;
        end
      end

      S_SCAN: begin
        if (rd_better) begin
          found_d     = 1'b1;
          best_idx_d  = idx_q;
          best_size_d = rd_size;
          best_addr_d = rd_addr;
        end
        if (idx_q == '0) begin
          state_d = S_PICK;
        end else begin
          ram_raddr = idx_q - IDX_W'(1);
          idx_d     = idx_q - IDX_W'(1);
        end
      end

      S_PICK: begin
        if (found_q) begin
          res_status_d = bfba_pkg::ST_OK;
          res_addr_d   = best_addr_ext[OW-1:0];
          res_size_d   = best_size_q;
          res_reused_d = 1'b1;
          idx_d        = best_idx_q;
          if (best_p1 < cnt_ext) begin
            // close the gap: move later entries down one slot
            ram_raddr = best_p1[IDX_W-1:0];
            state_d   = S_SHIFT;
          end else begin
            count_d = count_q - CNT_W'(1);
            state_d = S_DONE;
          end
        end else begin
          state_d = S_BUMP;
        end
      end

      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        if (idx_p2 < cnt_ext) begin
          ram_raddr = idx_p2[IDX_W-1:0];
          idx_d     = idx_p1[IDX_W-1:0];
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_DONE;
        end
      end

      S_BUMP: begin
        state_d = S_DONE;
        if (bump_oom) begin
          res_status_d = bfba_pkg::ST_OOM;
        end else begin
          bp_load      = 1'b1;
          res_status_d = bfba_pkg::ST_OK;
          res_addr_d   = grant_trunc[OW-1:0];
          res_size_d   = size_q;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
    end
  end

  // Configuration registers and break pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= bfba_pkg::HEAP_LIMIT_RST;
      bp_q    <= ADDR_BITS'(bfba_pkg::HEAP_BASE_RST);
    end else begin
      if (cfg_valid_i && (cfg_index_i == bfba_pkg::CFG_HEAP_BASE)) begin
        bp_q <= cfg_ext[ADDR_BITS-1:0];
      end else if (bp_load) begin
        bp_q <= bump_sum[ADDR_BITS-1:0];
      end
      if (cfg_valid_i && (cfg_index_i == bfba_pkg::CFG_HEAP_LIMIT)) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= opcode_i;
      size_q  <= request_size_i;
      paddr_q <= payload_address_i;
    end
    idx_q        <= idx_d;
    best_idx_q   <= best_idx_d;
    best_size_q  <= best_size_d;
    best_addr_q  <= best_addr_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_size_q   <= res_size_d;
    res_reused_q <= res_reused_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_size_q   <= res_size_q;
      out_reused_q <= res_reused_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign granted_address_o = out_addr_q;
  assign granted_size_o    = out_size_q;
  assign reused_o          = out_reused_q;

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int FREE_ENTRIES   = 16;
  localparam int HEADER_BYTES   = 16;
  localparam int ADDR_BITS      = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 150;
  localparam int HOLD_SPACING   = 900;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 40;
  localparam int SW             = bfba_pkg::SIZE_W;
  localparam int OW             = bfba_pkg::OUT_ADDR_W;
  localparam int IW             = bfba_pkg::CFG_IDX_W;
  localparam int DW             = bfba_pkg::CFG_DATA_W;

  // Register indexes the block does not decode
  localparam logic [IW-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [IW-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic          opcode;
    logic [SW-1:0] size;
    logic [OW-1:0] addr;
  } heap_req_t;

  typedef struct packed {
    bfba_pkg::status_e status;
    logic [OW-1:0]     addr;
    logic [SW-1:0]     size;
    logic              reused;
  } grant_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  // DUT connections
  logic          in_valid   = 1'b0;
  wire           in_ready;
  logic          req_opcode = bfba_pkg::OP_ALLOC;
  logic [SW-1:0] req_size   = '0;
  logic [OW-1:0] req_addr   = '0;
  wire           out_valid;
  logic          out_ready  = 1'b0;
  wire  [2:0]    status;
  wire  [OW-1:0] granted_address;
  wire  [SW-1:0] granted_size;
  wire           reused;
  logic          cfg_valid  = 1'b0;
  wire           cfg_ready;
  logic [IW-1:0] cfg_index  = bfba_pkg::CFG_HEAP_BASE;
  logic [DW-1:0] cfg_data   = '0;

  best_fit_block_allocator_unit #(
    .FREE_ENTRIES(FREE_ENTRIES),
    .HEADER_BYTES(HEADER_BYTES),
    .ADDR_BITS   (ADDR_BITS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .opcode_i         (req_opcode),
    .request_size_i   (req_size),
    .payload_address_i(req_addr),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .granted_address_o(granted_address),
    .granted_size_o   (granted_size),
    .reused_o         (reused),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  // Shared bookkeeping
  heap_req_t pending_reqs[$];
  grant_t    pending_grants[$];
  int        reqs_queued  = 0;
  int        results_done = 0;
  int        errors       = 0;
  int        quiet_cycles = 0;
  bit        calm         = 1'b0;
  bit        req_taken    = 1'b0;
  bit        res_taken    = 1'b0;
  bit        cfg_taken    = 1'b0;
  int        n_reused = 0, n_fresh = 0, n_oom = 0, n_full = 0, n_reject = 0;

  // Allocator state mirror
  logic [OW-1:0]        free_addr_tbl [FREE_ENTRIES];
  logic [SW-1:0]        free_size_tbl [FREE_ENTRIES];
  int                   free_cnt     = 0;
  logic [ADDR_BITS-1:0] brk_ptr      = bfba_pkg::HEAP_BASE_RST;
  logic [DW-1:0]        heap_limit_q = bfba_pkg::HEAP_LIMIT_RST;

  // Expected grant for one request; updates the mirrored heap state
  function automatic grant_t predict_grant(heap_req_t r);
    grant_t               g;
    int                   best;
    logic [ADDR_BITS:0]   next_brk;
    g.status = bfba_pkg::ST_OK;
    g.addr   = '0;
    g.size   = '0;
    g.reused = 1'b0;
    best     = -1;
    if (r.opcode == bfba_pkg::OP_FREE) begin
      if (r.addr == '0) begin
        g.status = bfba_pkg::ST_NULL;
      end else if (free_cnt >= FREE_ENTRIES) begin
        g.status = bfba_pkg::ST_FULL;
      end else begin
        free_addr_tbl[free_cnt] = r.addr;
        free_size_tbl[free_cnt] = r.size;
        free_cnt++;
      end
    end else if (r.size == '0) begin
      g.status = bfba_pkg::ST_ZERO;
    end else begin
      // smallest fit; scanning from the newest end keeps ties on the latest free
      for (int i = free_cnt - 1; i >= 0; i--) begin
        if (free_size_tbl[i] >= r.size &&
            (best < 0 || free_size_tbl[i] < free_size_tbl[best])) begin
          best = i;
        end
      end
      if (best >= 0) begin
        g.addr   = free_addr_tbl[best];
        g.size   = free_size_tbl[best];
        g.reused = 1'b1;
        for (int i = best; i < free_cnt - 1; i++) begin
          free_addr_tbl[i] = free_addr_tbl[i + 1];
          free_size_tbl[i] = free_size_tbl[i + 1];
        end
        free_cnt--;
      end else begin
        next_brk = {1'b0, brk_ptr} + HEADER_BYTES + r.size;
        if (next_brk[ADDR_BITS] || next_brk > {1'b0, heap_limit_q}) begin
          g.status = bfba_pkg::ST_OOM;
        end else begin
          g.addr  = brk_ptr + HEADER_BYTES;
          g.size  = r.size;
          brk_ptr = next_brk[ADDR_BITS-1:0];
        end
      end
    end
    return g;
  endfunction

  // Random request; sizes lean small and repeat so that ties and reuse are common
  function automatic heap_req_t rand_req(int free_pct);
    heap_req_t   r;
    int unsigned pick;
    r.opcode = ($urandom_range(99) < free_pct) ? bfba_pkg::OP_FREE : bfba_pkg::OP_ALLOC;
    pick = $urandom_range(99);
    if (pick < 45) begin
      r.size = $urandom_range(64, 1);
    end else if (pick < 65) begin
      r.size = 16 * $urandom_range(8, 1);
    end else if (pick < 78) begin
      r.size = $urandom_range(4096, 65);
    end else if (pick < 88) begin
      r.size = $urandom;
    end else if (pick < 93) begin
      r.size = '0;
    end else begin
      r.size = '1;
    end
    pick = $urandom_range(99);
    if (r.opcode == bfba_pkg::OP_FREE && pick < 6) begin
      r.addr = '0;
    end else if (pick < 10) begin
      r.addr = '1;
    end else begin
      r.addr = $urandom;
    end
    return r;
  endfunction

  task automatic queue_req(logic op, logic [SW-1:0] size, logic [OW-1:0] addr);
    heap_req_t r;
    r.opcode = op;
    r.size   = size;
    r.addr   = addr;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  // Every request yields one result, so idle means all results are back
  task automatic wait_drained();
    while (results_done < reqs_queued) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_random(int count, int free_pct);
    for (int i = 0; i < count; i++) begin
      pending_reqs.push_back(rand_req(free_pct));
      reqs_queued++;
    end
    wait_drained();
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk_i);
    while (!cfg_taken) @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Request driver: one beat at a time from the pending queue
  always @(negedge clk_i) begin
    if (!in_valid || req_taken) begin
      if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 8)) begin
        heap_req_t r;
        r = pending_reqs.pop_front();
        req_opcode <= r.opcode;
        req_size   <= r.size;
        req_addr   <= r.addr;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus long hold-offs that back the block up
  int hold_left    = 0;
  int next_hold_at = 300;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (results_done >= next_hold_at) begin
      hold_left    = HOLD_CYCLES;
      next_hold_at += HOLD_SPACING;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  // Monitor: check results, predict on accepted requests, track config, watchdog
  always @(posedge clk_i) begin : monitor_p
    grant_t    want;
    heap_req_t r;
    req_taken = in_valid && in_ready;
    res_taken = out_valid && out_ready;
    cfg_taken = cfg_valid && cfg_ready;
    if (rst_ni) begin
      if (res_taken) begin
        results_done++;
        if (pending_grants.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, status %0d addr %h", $time, status,
                   granted_address);
        end else begin
          want = pending_grants.pop_front();
          if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          end
          if (granted_address !== want.addr) begin
            errors++;
            $display("%0t: granted_address expected %h actual %h", $time, want.addr,
                     granted_address);
          end
          if (granted_size !== want.size) begin
            errors++;
            $display("%0t: granted_size expected %h actual %h", $time, want.size,
                     granted_size);
          end
          if (reused !== want.reused) begin
            errors++;
            $display("%0t: reused expected %b actual %b", $time, want.reused, reused);
          end
        end
      end
      if (req_taken) begin
        r.opcode = req_opcode;
        r.size   = req_size;
        r.addr   = req_addr;
        want = predict_grant(r);
        pending_grants.push_back(want);
        case (want.status)
          bfba_pkg::ST_OK: begin
            if (want.reused) n_reused++;
            else if (r.opcode == bfba_pkg::OP_ALLOC) n_fresh++;
          end
          bfba_pkg::ST_OOM:  n_oom++;
          bfba_pkg::ST_FULL: n_full++;
          default: n_reject++;
        endcase
      end
      if (cfg_taken) begin
        if (cfg_index == bfba_pkg::CFG_HEAP_BASE) begin
          brk_ptr = cfg_data;
        end else if (cfg_index == bfba_pkg::CFG_HEAP_LIMIT) begin
          heap_limit_q = cfg_data;
        end
      end
    end
    if (!rst_ni || req_taken || res_taken || cfg_taken) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Test sequence
  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Small heap for the directed part
    write_reg(bfba_pkg::CFG_HEAP_BASE, 32'h0000_1000);
    write_reg(bfba_pkg::CFG_HEAP_LIMIT, 32'h0004_0000);

    queue_req(bfba_pkg::OP_ALLOC, 24'd0, 32'h0);               // zero size
    queue_req(bfba_pkg::OP_ALLOC, 24'd100, 32'hFFFF_FFFF);     // bump from break pointer
    queue_req(bfba_pkg::OP_ALLOC, 24'hFF_FFFF, 32'h0);         // heap exhausted
    queue_req(bfba_pkg::OP_FREE, 24'd50, 32'h0);               // null free
    queue_req(bfba_pkg::OP_FREE, 24'd64, 32'h0000_2000);
    queue_req(bfba_pkg::OP_FREE, 24'd64, 32'h0000_3000);       // equal size, newer
    queue_req(bfba_pkg::OP_FREE, 24'd0, 32'h0000_4000);        // zero size entry, never fits
    queue_req(bfba_pkg::OP_FREE, 24'hFF_FFFF, 32'hFFFF_FFFF);
    queue_req(bfba_pkg::OP_ALLOC, 24'd64, 32'h0);              // tie goes to the newer block
    queue_req(bfba_pkg::OP_ALLOC, 24'd1, 32'h0);               // takes the head entry
    queue_req(bfba_pkg::OP_ALLOC, 24'hFF_FFFF, 32'h0);         // largest block reused
    // fill the table, last one overflows
    for (int i = 0; i < FREE_ENTRIES; i++) begin
      queue_req(bfba_pkg::OP_FREE, 24'(8 * (i + 1)), 32'h0001_0000 + 32'(i * 256));
    end
    wait_drained();

    run_random(400, 50);

    // Top of the address space, maximum limit; unused indexes are ignored
    write_reg(CFG_SPARE_2, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_3, 32'hA5A5_5A5A);
    write_reg(bfba_pkg::CFG_HEAP_BASE, 32'hFFFF_0000);
    write_reg(bfba_pkg::CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
    run_random(400, 35);

    // Empty heap: only reuse can succeed; no random gaps or stalls in this stretch
    write_reg(bfba_pkg::CFG_HEAP_BASE, 32'h0000_0000);
    write_reg(bfba_pkg::CFG_HEAP_LIMIT, 32'h0000_0000);
    calm = 1'b1;
    run_random(300, 60);
    calm = 1'b0;

    // Tight heap that runs out during the phase
    write_reg(bfba_pkg::CFG_HEAP_BASE, 32'h0010_0000);
    write_reg(bfba_pkg::CFG_HEAP_LIMIT, 32'h0010_2000);
    run_random(500, 40);

    // Break pointer at the very top: every bump wraps
    write_reg(bfba_pkg::CFG_HEAP_BASE, 32'hFFFF_FFFF);
    write_reg(bfba_pkg::CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
    run_random(400, 50);

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (pending_grants.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_grants.size());
    end

    $display("Ran %0d requests over 5 heap settings: %0d reused, %0d fresh grants,",
             reqs_queued, n_reused, n_fresh);
    $display("  %0d out of memory, %0d table full, %0d zero-size or null; %0d mismatches",
             n_oom, n_full, n_reject, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/bfba_pkg.sv
design/bfba_ram.sv
design/best_fit_block_allocator_unit.sv
sim/testbench.sv
